### rtl/core/oas_pkg.sv
// ----------------------------------------------------------------------------
// oas_pkg
// shared constants, beat types and inter-module structs of the overlap
// alignment score block
// ----------------------------------------------------------------------------
`default_nettype none

package oas_pkg;

  // longest sequence held by the cell chain
  localparam int MAX_LEN   = 1024;
  // counters that can hold MAX_LEN itself
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  // index of one cell
  localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  // signed score, lowest value is about -255 * MAX_LEN
  localparam int SCORE_W   = $clog2(256 * MAX_LEN + 1) + 1;
  localparam int SYM_W     = 8;
  localparam int PEN_W     = 8;
  localparam int OUT_W     = 11;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 2'd1;

  // input beat kinds
  localparam logic KIND_B = 1'b0;
  localparam logic KIND_A = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_W-1:0] best_score;
    logic [OUT_W-1:0] end_row;
    logic [OUT_W-1:0] end_col;
  } out_beat_t;

  // row token passed from cell to cell
  typedef struct packed {
    logic                      valid;
    logic [SYM_W-1:0]          sym;
    logic signed [SCORE_W-1:0] left;
    logic signed [SCORE_W-1:0] diag;
  } tok_t;

  // b symbol shifted towards the head while loading
  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] sym;
  } bsym_t;

  typedef struct packed {
    logic load_b;
    logic scan;
    logic clear;
  } chain_ctl_t;

  typedef struct packed {
    logic                      valid;
    logic signed [SCORE_W-1:0] value;
    logic [LEN_W-1:0]          row;
    logic [LEN_W-1:0]          col;
  } offer_t;

  typedef struct packed {
    logic [LEN_W-1:0] value;
    logic [LEN_W-1:0] row;
    logic [LEN_W-1:0] col;
  } best_t;

endpackage

`default_nettype wire

### rtl/core/overlap_alignment_score.sv
// ----------------------------------------------------------------------------
// overlap_alignment_score
// throughput: one B or A beat per cycle, input closed after the last A beat
//   until the result is in the output register
// the result follows the last A beat once the row token has drained through
//   the MAX_LEN cell chain, the last row has been shifted out of the chain
//   one cell per cycle and the output register is free
// reset: synchronous, clears the cells, counters and penalties at once
// ----------------------------------------------------------------------------
`default_nettype none

module overlap_alignment_score (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  oas_pkg::in_beat_t                     in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output oas_pkg::out_beat_t                    out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [oas_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [oas_pkg::PEN_W-1:0]             cfg_data
);

  typedef enum logic [1:0] {
    ST_ACCEPT,  // loading b, then streaming a rows
    ST_DRAIN,   // waiting for the last row token to leave the tail
    ST_SCAN,    // shifting the last row out at the head
    ST_FINISH   // handing the result to the output register
  } state_t;

  state_t                            state_r;
  logic                              in_a_phase_r;
  logic [oas_pkg::LEN_W-1:0]         b_len_r;      // b symbols held
  logic [oas_pkg::LEN_W-1:0]         rows_r;       // rows injected
  logic [oas_pkg::LEN_W-1:0]         rows_out_r;   // rows seen at the tail
  logic [oas_pkg::IDX_W-1:0]         scan_k_r;
  logic [oas_pkg::PEN_W-1:0]         mis_r, gap_r;
  logic                              out_vld_r;
  oas_pkg::out_beat_t                out_data_r;

  logic                              in_acc, is_a, load_b, inject, out_free, finish;
  logic [oas_pkg::LEN_W-1:0]         scan_col;
  oas_pkg::chain_ctl_t               ctl;
  oas_pkg::tok_t                     head_tok, tail_tok;
  oas_pkg::bsym_t                    b_new;
  logic signed [oas_pkg::SCORE_W-1:0] head_score;
  oas_pkg::offer_t                   offer;
  oas_pkg::best_t                    best;

  assign in_ready  = (state_r == ST_ACCEPT);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign is_a      = (in_data.kind == oas_pkg::KIND_A);

  // b beats beyond MAX_LEN are dropped, late b beats ignored
  assign load_b = in_acc && !is_a && !in_a_phase_r
                  && (b_len_r != oas_pkg::LEN_W'(oas_pkg::MAX_LEN));
  // a beats beyond MAX_LEN compute no row
  assign inject = in_acc && is_a && (rows_r != oas_pkg::LEN_W'(oas_pkg::MAX_LEN));

  assign out_free = !out_vld_r || out_ready;
  assign finish   = (state_r == ST_FINISH) && out_free;

  assign ctl = '{load_b: load_b, scan: (state_r == ST_SCAN), clear: finish};

  // b symbols enter at the tail, so b[1..m] sit in the last m cells and the
  // last column is always the tail cell; the empty cells in front act as a
  // zero border and a plain delay for the row tokens
  assign head_tok = '{valid: inject, sym: in_data.symbol, left: '0, diag: '0};
  assign b_new    = '{valid: 1'b1, sym: in_data.symbol};

  oas_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .mis        (mis_r),
    .gap        (gap_r),
    .head_tok   (head_tok),
    .b_new      (b_new),
    .tail_tok   (tail_tok),
    .head_score (head_score)
  );

  // the cell seen at the head in scan step k holds column k + m + 1 - MAX_LEN;
  // empty cells hold zero and never win, so their column does not matter
  assign scan_col = oas_pkg::LEN_W'(scan_k_r) + b_len_r + oas_pkg::LEN_W'(1)
                    - oas_pkg::LEN_W'(oas_pkg::MAX_LEN);

  // last column offers arrive in row order at the tail, then the last row
  // is offered left to right during the scan
  always_comb begin
    if (state_r == ST_SCAN) begin
      offer = '{valid: 1'b1, value: head_score, row: rows_r, col: scan_col};
    end else begin
      offer = '{valid: tail_tok.valid, value: tail_tok.left,
                row: rows_out_r + oas_pkg::LEN_W'(1), col: b_len_r};
    end
  end

  oas_best u_best (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (finish),
    .offer (offer),
    .best  (best)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_ACCEPT;
      in_a_phase_r <= 1'b0;
      b_len_r      <= '0;
      rows_r       <= '0;
      rows_out_r   <= '0;
      scan_k_r     <= '0;
      mis_r        <= '0;
      gap_r        <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          oas_pkg::CFG_MISMATCH: mis_r <= cfg_data;
          oas_pkg::CFG_GAP:      gap_r <= cfg_data;
          default: ;
        endcase
      end

      // a result taken in the same cycle as the next one is loaded stays valid
      if (out_vld_r && out_ready && !finish) begin
        out_vld_r <= 1'b0;
      end

      if (tail_tok.valid) begin
        rows_out_r <= rows_out_r + oas_pkg::LEN_W'(1);
      end

      case (state_r)
        ST_ACCEPT: begin
          if (load_b) begin
            b_len_r <= b_len_r + oas_pkg::LEN_W'(1);
          end
          // an a beat or the last b beat closes the loading of b
          if (in_acc && (is_a || in_data.last)) begin
            in_a_phase_r <= 1'b1;
          end
          if (inject) begin
            rows_r <= rows_r + oas_pkg::LEN_W'(1);
          end
          if (in_acc && is_a && in_data.last) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if ((rows_out_r == rows_r) && !tail_tok.valid) begin
            state_r  <= ST_SCAN;
            scan_k_r <= '0;
          end
        end
        ST_SCAN: begin
          scan_k_r <= scan_k_r + oas_pkg::IDX_W'(1);
          if (scan_k_r == oas_pkg::IDX_W'(oas_pkg::MAX_LEN - 1)) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_vld_r    <= 1'b1;
            out_data_r   <= '{best_score: oas_pkg::OUT_W'(best.value),
                              end_row:    oas_pkg::OUT_W'(best.row),
                              end_col:    oas_pkg::OUT_W'(best.col)};
            state_r      <= ST_ACCEPT;
            in_a_phase_r <= 1'b0;
            b_len_r      <= '0;
            rows_r       <= '0;
            rows_out_r   <= '0;
          end
        end
        default: begin
          state_r <= ST_ACCEPT;
        end
      endcase
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### rtl/core/oas_cell.sv
// ----------------------------------------------------------------------------
// oas_cell
// one column of the score matrix: holds a b symbol and the score above,
// scores each passing row token and hands it on to the next cell
// ----------------------------------------------------------------------------
`default_nettype none

module oas_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  oas_pkg::chain_ctl_t                ctl,
  input  logic [oas_pkg::PEN_W-1:0]          mis,
  input  logic [oas_pkg::PEN_W-1:0]          gap,
  input  oas_pkg::tok_t                      tok_i,
  output oas_pkg::tok_t                      tok_o,
  input  oas_pkg::bsym_t                     b_i,
  output oas_pkg::bsym_t                     b_o,
  input  logic signed [oas_pkg::SCORE_W-1:0] above_i,
  output logic signed [oas_pkg::SCORE_W-1:0] above_o
);

  localparam logic signed [oas_pkg::SCORE_W-1:0] ONE = oas_pkg::SCORE_W'(1);

  logic signed [oas_pkg::SCORE_W-1:0] mis_s, gap_s;
  logic signed [oas_pkg::SCORE_W-1:0] cand_d, cand_u, cand_l, score;
  logic signed [oas_pkg::SCORE_W-1:0] above_r, above_nxt;
  logic                               b_vld_r, b_vld_nxt;
  logic [oas_pkg::SYM_W-1:0]          b_sym_r;
  logic                               tok_vld_r;
  logic [oas_pkg::SYM_W-1:0]          tok_sym_r;
  logic signed [oas_pkg::SCORE_W-1:0] tok_left_r, tok_diag_r;

  assign mis_s = $signed(oas_pkg::SCORE_W'(mis));
  assign gap_s = $signed(oas_pkg::SCORE_W'(gap));

  always_comb begin
    cand_d = (tok_i.sym == b_sym_r) ? tok_i.diag + ONE : tok_i.diag - mis_s;
    cand_u = above_r - gap_s;
    cand_l = tok_i.left - gap_s;
    score  = cand_d;
    if (cand_u > score) begin
      score = cand_u;
    end
    if (cand_l > score) begin
      score = cand_l;
    end
  end

  always_comb begin
    if (ctl.clear) begin
      above_nxt = '0;
    end else if (ctl.scan) begin
      above_nxt = above_i;
    end else if (tok_i.valid && b_vld_r) begin
      above_nxt = score;
    end else begin
      above_nxt = above_r;
    end
  end

  always_comb begin
    if (ctl.clear) begin
      b_vld_nxt = 1'b0;
    end else if (ctl.load_b) begin
      b_vld_nxt = b_i.valid;
    end else begin
      b_vld_nxt = b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r   <= '0;
      b_vld_r   <= 1'b0;
      tok_vld_r <= 1'b0;
    end else begin
      above_r   <= above_nxt;
      b_vld_r   <= b_vld_nxt;
      tok_vld_r <= tok_i.valid && !ctl.clear;
    end
  end

  // empty cells pass a zero border to their right
  always_ff @(posedge clk) begin
    if (ctl.load_b) begin
      b_sym_r <= b_i.sym;
    end
    tok_sym_r  <= tok_i.sym;
    tok_left_r <= b_vld_r ? score : '0;
    tok_diag_r <= above_r;
  end

  assign tok_o   = '{valid: tok_vld_r, sym: tok_sym_r, left: tok_left_r, diag: tok_diag_r};
  assign b_o     = '{valid: b_vld_r, sym: b_sym_r};
  assign above_o = above_r;

endmodule

`default_nettype wire

### rtl/core/oas_chain.sv
// ----------------------------------------------------------------------------
// oas_chain
// row of MAX_LEN cells: row tokens run head to tail, b symbols and scan
// values run tail to head
// ----------------------------------------------------------------------------
`default_nettype none

module oas_chain (
  input  logic                               clk,
  input  logic                               rst_n,
  input  oas_pkg::chain_ctl_t                ctl,
  input  logic [oas_pkg::PEN_W-1:0]          mis,
  input  logic [oas_pkg::PEN_W-1:0]          gap,
  input  oas_pkg::tok_t                      head_tok,
  input  oas_pkg::bsym_t                     b_new,
  output oas_pkg::tok_t                      tail_tok,
  output logic signed [oas_pkg::SCORE_W-1:0] head_score
);

  oas_pkg::tok_t                      tok_w   [oas_pkg::MAX_LEN+1];
  oas_pkg::bsym_t                     b_w     [oas_pkg::MAX_LEN+1];
  logic signed [oas_pkg::SCORE_W-1:0] above_w [oas_pkg::MAX_LEN+1];

  assign tok_w[0]                  = head_tok;
  assign b_w[oas_pkg::MAX_LEN]     = b_new;
  assign above_w[oas_pkg::MAX_LEN] = '0;

  for (genvar k = 0; k < oas_pkg::MAX_LEN; k++) begin : g_cell
    oas_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .mis     (mis),
      .gap     (gap),
      .tok_i   (tok_w[k]),
      .tok_o   (tok_w[k+1]),
      .b_i     (b_w[k+1]),
      .b_o     (b_w[k]),
      .above_i (above_w[k+1]),
      .above_o (above_w[k])
    );
  end

  assign tail_tok   = tok_w[oas_pkg::MAX_LEN];
  assign head_score = above_w[0];

endmodule

`default_nettype wire

### rtl/core/oas_best.sv
// ----------------------------------------------------------------------------
// oas_best
// keeps the best positive score offered so far and where it was found
// ----------------------------------------------------------------------------
`default_nettype none

module oas_best (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            clear,
  input  oas_pkg::offer_t offer,
  output oas_pkg::best_t  best
);

  logic [oas_pkg::LEN_W-1:0]   val_r, row_r, col_r;
  logic [oas_pkg::SCORE_W-1:0] val_ext;
  logic                        take;

  assign val_ext = oas_pkg::SCORE_W'(val_r);

  // strictly greater only, so the earliest cell wins a tie
  assign take = offer.valid && !offer.value[oas_pkg::SCORE_W-1] && (offer.value != '0)
                && ($unsigned(offer.value) > val_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
      row_r <= '0;
      col_r <= '0;
    end else if (clear) begin
      val_r <= '0;
      row_r <= '0;
      col_r <= '0;
    end else if (take) begin
      val_r <= oas_pkg::LEN_W'($unsigned(offer.value));
      row_r <= offer.row;
      col_r <= offer.col;
    end
  end

  assign best = '{value: val_r, row: row_r, col: col_r};

endmodule

`default_nettype wire

### rtl/core/oas_checker.sv
// ----------------------------------------------------------------------------
// oas_checker
// port level checks of the overlap alignment score block, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

module oas_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input oas_pkg::in_beat_t             in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input oas_pkg::out_beat_t            out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // the last a beat closes the input until the job is done
  a_in_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.kind == oas_pkg::KIND_A) && in_data.last
    |=> !in_ready)
    else $error("input still open after last a beat");

  // a result is only produced while the input is closed
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while input open");

  // a zero score carries no position
  a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.best_score == '0)
    |-> (out_data.end_row == '0) && (out_data.end_col == '0))
    else $error("position given for zero score");

  // a positive score always has a position
  a_pos_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.best_score != '0)
    |-> (out_data.end_row != '0) && (out_data.end_col != '0))
    else $error("positive score without position");

endmodule

bind overlap_alignment_score oas_checker u_oas_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for overlap_alignment_score: drives b and a symbol
// beats, keeps its own score matrix per job and compares every result beat
// with the best cell it predicts for that job
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oas_pkg::*;

  localparam int PERIOD       = 20;
  // wait from the last a beat until the result leaves the chain
  localparam int LATENCY      = 2 * MAX_LEN + 2;
  localparam int SETTLE       = LATENCY + 16;
  // slowest run is some 50 jobs at full latency plus the long hold-off,
  // the long b load and the settle pauses, well inside CYCLE_LIMIT
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int HOLD_CYCLES  = 3 * LATENCY;
  localparam int RANDOM_BEATS = 120;
  localparam int CFG_EVERY    = 150;

  // index past the two penalty registers, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_beat_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_beat_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MISMATCH;
  logic [PEN_W-1:0] cfg_data  = '0;

  overlap_alignment_score dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // bench state
  // ---------------------------------------------------------------------------
  int failures      = 0;
  int cycle_count   = 0;
  int stim_count    = 0;  // beats that did something, late b beats excluded
  int send_idle_pct = 18;
  int recv_idle_pct = 51;
  int holds_asked   = 0;  // bumped by a test to ask for a long hold-off
  int holds_served  = 0;
  int hold_left     = 0;

  // own copy of the penalties and of the job state
  int               mis_pen = 0;
  int               gap_pen = 0;
  logic [SYM_W-1:0] b_seq [MAX_LEN];
  int               prev_row [MAX_LEN];
  int               b_count, rows_done, top_score, top_row, top_col;
  bit               rows_phase;

  out_beat_t pending_scores[$];

  // ---------------------------------------------------------------------------
  // score predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_alignment();
    foreach (prev_row[j]) prev_row[j] = 0;
    b_count    = 0;
    rows_done  = 0;
    top_score  = 0;
    top_row    = 0;
    top_col    = 0;
    rows_phase = 1'b0;
  endfunction

  // strictly greater only, so the earliest cell of the search wins a tie
  function automatic void consider_cell(input int v, input int r, input int c);
    if (v > 0 && v > top_score) begin
      top_score = v;
      top_row   = r;
      top_col   = c;
    end
  endfunction

  // one full row of the matrix for this a symbol, borders are zero
  function automatic void score_row(input logic [SYM_W-1:0] a_sym);
    int diag, left, up, cur;
    diag = 0;
    left = 0;
    for (int j = 0; j < b_count; j++) begin
      up   = prev_row[j];
      cur  = diag + ((a_sym == b_seq[j]) ? 1 : -mis_pen);
      if (up - gap_pen > cur) cur = up - gap_pen;
      if (left - gap_pen > cur) cur = left - gap_pen;
      diag        = up;
      prev_row[j] = cur;
      left        = cur;
    end
  endfunction

  // returns 0 for a beat the block simply drops (b symbol in the a phase)
  function automatic bit predict_alignment(input in_beat_t beat);
    out_beat_t res;
    if (beat.kind == KIND_B) begin
      if (rows_phase) return 1'b0;
      // b beyond MAX_LEN is lost, its last flag still counts
      if (b_count < MAX_LEN) begin
        b_seq[b_count] = beat.symbol;
        b_count++;
      end
      if (beat.last) rows_phase = 1'b1;
      return 1'b1;
    end
    // an a beat also closes an unfinished b load
    rows_phase = 1'b1;
    if (rows_done < MAX_LEN) begin
      score_row(beat.symbol);
      rows_done++;
      // last column, top to bottom as rows complete
      if (b_count > 0) consider_cell(prev_row[b_count - 1], rows_done, b_count);
    end
    if (beat.last) begin
      // then the last row, left to right
      for (int j = 0; j < b_count; j++) consider_cell(prev_row[j], rows_done, j + 1);
      res.best_score = OUT_W'(top_score);
      res.end_row    = OUT_W'(top_row);
      res.end_col    = OUT_W'(top_col);
      pending_scores = {pending_scores, res};
      clear_alignment();
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  function automatic void check_score(input out_beat_t got);
    out_beat_t want;
    if (pending_scores.size() == 0) begin
      $display("%0t: unexpected result beat, score %0d row %0d col %0d",
               $time, got.best_score, got.end_row, got.end_col);
      failures++;
      return;
    end
    want = pending_scores.pop_front();
    if (got.best_score !== want.best_score) begin
      $display("%0t: best_score expected %0d got %0d", $time, want.best_score,
               got.best_score);
      failures++;
    end
    if (got.end_row !== want.end_row) begin
      $display("%0t: end_row expected %0d got %0d", $time, want.end_row, got.end_row);
      failures++;
    end
    if (got.end_col !== want.end_col) begin
      $display("%0t: end_col expected %0d got %0d", $time, want.end_col, got.end_col);
      failures++;
    end
  endfunction

  // result side: check on each beat, then pick ready for the next cycle;
  // a requested hold-off keeps ready low while hold_left counts down from HOLD_CYCLES
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_score(out_data);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
        out_ready    <= 1'b0;
        hold_left    <= HOLD_CYCLES;
        holds_served <= holds_served + 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time,
               pending_scores.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_beat_t mk_beat(input logic kind, input logic [SYM_W-1:0] sym,
                                       input logic last);
    in_beat_t b;
    b.kind   = kind;
    b.symbol = sym;
    b.last   = last;
    return b;
  endfunction

  // valid only drops when an idle gap is chosen, so it is never lowered and
  // raised in one time step
  task automatic send_beat(input in_beat_t beat);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    if (predict_alignment(beat)) stim_count++;
  endtask

  // sender pauses until every result is back, then the chain gets time to
  // finish any work that left no result
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [PEN_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_penalties(input logic [PEN_W-1:0] mis, input logic [PEN_W-1:0] gap,
                                   input bit poke_spare);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_beat(CFG_MISMATCH, mis);
    cfg_beat(CFG_GAP, gap);
    if (poke_spare) cfg_beat(CFG_SPARE, PEN_W'($urandom_range(255)));
    cfg_valid <= 1'b0;
    mis_pen = int'(mis);
    gap_pen = int'(gap);
  endtask

  function automatic logic [PEN_W-1:0] pick_penalty();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return PEN_W'($urandom_range(1, 3));
      default: return PEN_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [SYM_W-1:0] pick_symbol(input bit full,
                                                   input logic [SYM_W-1:0] alpha[$]);
    if (full) return SYM_W'($urandom_range(255));
    return alpha[$urandom_range(alpha.size() - 1)];
  endfunction

  // one job: mostly a clean b load then a rows, sometimes a broken one;
  // always closed by a last a beat so the block ends up idle
  task automatic send_job(input int b_max, input int a_max);
    in_beat_t         beats[$];
    logic [SYM_W-1:0] alpha[$];
    bit               full;
    int               nb, na, style;
    full = ($urandom_range(3) == 0);
    repeat ($urandom_range(1, 4)) alpha = {alpha, SYM_W'($urandom_range(255))};
    nb    = $urandom_range(1, b_max);
    na    = $urandom_range(1, a_max);
    style = ($urandom_range(99) < 80) ? 0 : $urandom_range(1, 4);
    case (style)
      1: begin
        // b load never flagged, first a beat closes it
        repeat (nb) beats = {beats, mk_beat(KIND_B, pick_symbol(full, alpha), 1'b0)};
        for (int i = 0; i < na; i++)
          beats = {beats, mk_beat(KIND_A, pick_symbol(full, alpha), i == na - 1)};
      end
      2: begin
        // stray b beats among the rows
        for (int i = 0; i < nb; i++)
          beats = {beats, mk_beat(KIND_B, pick_symbol(full, alpha), i == nb - 1)};
        for (int i = 0; i < na; i++) begin
          if ($urandom_range(2) == 0)
            beats = {beats, mk_beat(KIND_B, pick_symbol(full, alpha),
                                    1'($urandom_range(1)))};
          beats = {beats, mk_beat(KIND_A, pick_symbol(full, alpha), i == na - 1)};
        end
      end
      3: begin
        // no b at all
        for (int i = 0; i < na; i++)
          beats = {beats, mk_beat(KIND_A, pick_symbol(full, alpha), i == na - 1)};
      end
      4: begin
        // noise: any kind, any flag
        repeat ($urandom_range(1, 12))
          beats = {beats, mk_beat(1'($urandom_range(1)), pick_symbol(full, alpha),
                                  $urandom_range(3) == 0)};
        beats = {beats, mk_beat(KIND_A, pick_symbol(full, alpha), 1'b1)};
      end
      default: begin
        for (int i = 0; i < nb; i++)
          beats = {beats, mk_beat(KIND_B, pick_symbol(full, alpha), i == nb - 1)};
        for (int i = 0; i < na; i++)
          beats = {beats, mk_beat(KIND_A, pick_symbol(full, alpha), i == na - 1)};
      end
    endcase
    foreach (beats[k]) send_beat(beats[k]);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // penalties untouched since reset, so both should read as zero
  task automatic test_reset_penalties();
    send_beat(mk_beat(KIND_B, 8'h00, 1'b0));
    send_beat(mk_beat(KIND_B, 8'hFF, 1'b1));
    send_beat(mk_beat(KIND_A, 8'hFF, 1'b0));
    send_beat(mk_beat(KIND_A, 8'h00, 1'b1));
  endtask

  task automatic test_special_cases();
    program_penalties(8'd1, 8'd1, 1'b0);
    // no b symbols at all: zero score and position
    send_beat(mk_beat(KIND_A, 8'h5A, 1'b1));
    // b load without a last flag, the first a beat ends it
    send_beat(mk_beat(KIND_B, 8'h11, 1'b0));
    send_beat(mk_beat(KIND_B, 8'h22, 1'b0));
    send_beat(mk_beat(KIND_A, 8'h22, 1'b0));
    send_beat(mk_beat(KIND_A, 8'h11, 1'b1));
    // b beat during the rows is dropped along with its last flag
    send_beat(mk_beat(KIND_B, 8'h33, 1'b1));
    send_beat(mk_beat(KIND_A, 8'h33, 1'b0));
    send_beat(mk_beat(KIND_B, 8'h33, 1'b1));
    send_beat(mk_beat(KIND_A, 8'h33, 1'b1));
    // equal scores in the last column and last row, column cell wins
    send_beat(mk_beat(KIND_B, 8'h05, 1'b0));
    send_beat(mk_beat(KIND_B, 8'h06, 1'b1));
    send_beat(mk_beat(KIND_A, 8'h06, 1'b0));
    send_beat(mk_beat(KIND_A, 8'h05, 1'b1));
  endtask

  // every register at its extremes, plus a write to an unused index
  task automatic test_register_extremes();
    logic [PEN_W-1:0] mis_set [4] = '{8'd255, 8'd0, 8'd255, 8'd0};
    logic [PEN_W-1:0] gap_set [4] = '{8'd255, 8'd255, 8'd0, 8'd0};
    for (int k = 0; k < 4; k++) begin
      program_penalties(mis_set[k], gap_set[k], k == 0);
      repeat (3) send_job(6, 6);
    end
  endtask

  // full length b plus two spare beats: the extra b symbols are lost, every
  // cell of the chain holds a column and the two rows see all of them
  task automatic test_length_overflow();
    program_penalties(8'd1, 8'd1, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 0; k < MAX_LEN + 2; k++)
      send_beat(mk_beat(KIND_B, (k < MAX_LEN) ? 8'hC3 : 8'h3C, k == MAX_LEN + 1));
    send_beat(mk_beat(KIND_A, 8'hC3, 1'b0));
    send_beat(mk_beat(KIND_A, 8'hC3, 1'b1));
  endtask

  task automatic test_random_jobs();
    int goal, next_cfg;
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      goal     = stim_count + RANDOM_BEATS / 3;
      next_cfg = stim_count;
      while (stim_count < goal) begin
        if (stim_count >= next_cfg) begin
          program_penalties(pick_penalty(), pick_penalty(), $urandom_range(3) == 0);
          next_cfg = stim_count + CFG_EVERY;
        end
        // mostly short sequences, now and then a longer one
        send_job(($urandom_range(24) == 0) ? 40 : 12, ($urandom_range(24) == 0) ? 40 : 12);
      end
    end
  endtask

  // long result stall while the sender keeps offering jobs, so the block
  // has to hold results and push back on its input
  task automatic test_backpressure();
    program_penalties(pick_penalty(), pick_penalty(), 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holds_asked <= holds_asked + 1;
    repeat (10) send_job(8, 8);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    clear_alignment();

    test_reset_penalties();
    test_special_cases();
    test_register_extremes();
    test_length_overflow();
    test_random_jobs();
    test_backpressure();

    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    // catch any stray result beats after the last one expected
    repeat (LATENCY + 100) @(posedge clk);

    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
